[src/assert_macros.svh]
// assertion macros used by the checks in the result queue module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define RQI_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rqi check failed");

// implication checked in the same cycle
`define RQI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rqi check failed");

`endif

[src/rqi_pkg.sv]
// shared types, constants and codes of the ray/quadric intersection block
`timescale 1ns / 1ps

package rqi_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int SAT_SH      = 32 - FRAC_BITS;
    localparam int ABC_W       = 67;
    localparam int RED_W       = 64;
    localparam int NUM_W       = 66;
    localparam int RAD_W       = 126;
    localparam int ROOT_W      = 63;
    localparam int REM_W       = 65;
    localparam int SQRT_STEPS  = 63;
    localparam int DIV_STEPS   = 32;
    localparam int DIST_W      = 32;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    localparam logic signed [ABC_W-1:0] UNIT = ABC_W'(1) <<< (2 * FRAC_BITS);

    // shape mode codes
    localparam logic [2:0] MODE_PLANE     = 3'd0;
    localparam logic [2:0] MODE_CYL       = 3'd1;
    localparam logic [2:0] MODE_SPHERE    = 3'd2;
    localparam logic [2:0] MODE_HYP_NEG   = 3'd3;
    localparam logic [2:0] MODE_HYP_ZERO  = 3'd4;
    localparam logic [2:0] MODE_HYP_POS   = 3'd5;
    localparam logic [2:0] MODE_PARAB     = 3'd6;
    localparam logic [2:0] MODE_HYP_PARAB = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_SHAPE_MODE = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_X   = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_Y   = 2'd2;
    localparam logic [1:0] CFG_ORIGIN_Z   = 2'd3;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_SINGLE,
        KIND_QUAD
    } kind_t;

    typedef struct packed {
        logic [2:0]  shape_mode;
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] origin_z;
    } cfg_t;

    // classified ray: single quotient num/den, or quadratic with num=b, den=a
    typedef struct packed {
        kind_t                   kind;
        logic signed [NUM_W-1:0] num;
        logic signed [NUM_W-1:0] den;
    } side_t;

    typedef struct packed {
        logic [1:0]             hit;
        logic [1:0][DIST_W-1:0] distance;
    } result_t;

endpackage

[src/rqi_front.sv]
// front: products, quadric terms, classification and discriminant
`timescale 1ns / 1ps

module rqi_front
    import rqi_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  cfg_t             cfg,
    input  logic             in_valid,
    input  logic [31:0]      dir_x,
    input  logic [31:0]      dir_y,
    input  logic [31:0]      dir_z,
    output logic             out_valid,
    output logic [RAD_W-1:0] out_rad,
    output side_t            out_side
);

    function automatic logic fits62(input logic [ABC_W-1:0] v);
        return (&v[ABC_W-1:62]) || (~|v[ABC_W-1:62]);
    endfunction

    logic [6:0] vld_reg;

    // stage 1: products
    logic signed [63:0] pxx_reg, pyy_reg, pzz_reg, pxo_reg, pyo_reg, pzo_reg;
    logic signed [63:0] poxx_reg, poyy_reg, pozz_reg;
    logic signed [31:0] dz1_reg, oz1_reg;
    logic [2:0]         mode1_reg;
    logic signed [31:0] dx, dy, dz, ox, oy, oz;

    // stage 2: a, b, c
    logic signed [ABC_W-1:0] a_reg, b_reg, c_reg, a_next, b_next, c_next;
    logic signed [ABC_W-1:0] t_xx, t_yy, t_zz, t_xo, t_yo, t_zo;
    logic signed [ABC_W-1:0] t_oxx, t_oyy, t_ozz, t_dzh, t_ozo;
    logic                    lin_reg, lin_next, plane_reg, plane_next;
    logic signed [31:0]      dz2_reg, oz2_reg;

    // stage 3: reduced terms and classification
    logic signed [RED_W-1:0] ar_reg, br_reg, cr_reg, ar_next, br_next, cr_next;
    logic                    fit;
    side_t                   side3_reg, side3_next;

    // stage 4: magnitudes
    logic [63:0] br_mag_reg, ar_mag_reg, cr_mag_reg;
    logic        ac_neg4_reg;
    side_t       side4_reg;

    // stage 5: partial products
    logic [63:0] bb_ll_reg, bb_lh_reg, bb_hh_reg;
    logic [63:0] ac_ll_reg, ac_lh_reg, ac_hl_reg, ac_hh_reg;
    logic        ac_neg5_reg;
    side_t       side5_reg;

    // stage 6: full squares
    logic [127:0] p1_reg, p2_reg, p1_next, p2_next;
    logic         ac_neg6_reg;
    side_t        side6_reg;

    // stage 7: discriminant
    logic [128:0]     d_next;
    logic [RAD_W-1:0] rad_reg;
    side_t            side7_reg, side7_next;

    assign dx = $signed(dir_x);
    assign dy = $signed(dir_y);
    assign dz = $signed(dir_z);
    assign ox = $signed(cfg.origin_x);
    assign oy = $signed(cfg.origin_y);
    assign oz = $signed(cfg.origin_z);

    always_comb
    begin
        t_xx  = ABC_W'(pxx_reg);
        t_yy  = ABC_W'(pyy_reg);
        t_zz  = ABC_W'(pzz_reg);
        t_xo  = ABC_W'(pxo_reg);
        t_yo  = ABC_W'(pyo_reg);
        t_zo  = ABC_W'(pzo_reg);
        t_oxx = ABC_W'(poxx_reg);
        t_oyy = ABC_W'(poyy_reg);
        t_ozz = ABC_W'(pozz_reg);
        t_dzh = ABC_W'(dz1_reg) <<< (FRAC_BITS - 1);
        t_ozo = ABC_W'(oz1_reg) <<< FRAC_BITS;
        a_next     = '0;
        b_next     = '0;
        c_next     = '0;
        lin_next   = 1'b0;
        plane_next = 1'b0;
        unique case (mode1_reg) inside
            MODE_PLANE:
            begin
                plane_next = 1'b1;
            end
            MODE_CYL:
            begin
                a_next = t_xx + t_yy;
                b_next = -t_xo - t_yo;
                c_next = t_oxx + t_oyy - UNIT;
            end
            MODE_SPHERE:
            begin
                a_next = t_xx + t_yy + t_zz;
                b_next = -t_xo - t_yo - t_zo;
                c_next = t_oxx + t_oyy + t_ozz - UNIT;
            end
            MODE_HYP_NEG, MODE_HYP_ZERO, MODE_HYP_POS:
            begin
                a_next   = t_xx + t_yy - t_zz;
                b_next   = -t_xo - t_yo + t_zo;
                c_next   = t_oxx + t_oyy - t_ozz;
                lin_next = 1'b1;
                if (mode1_reg == MODE_HYP_NEG)
                begin
                    c_next = t_oxx + t_oyy - t_ozz - UNIT;
                end
                else if (mode1_reg == MODE_HYP_POS)
                begin
                    c_next = t_oxx + t_oyy - t_ozz + UNIT;
                end
            end
            MODE_PARAB:
            begin
                a_next = t_xx + t_yy;
                b_next = -t_xo - t_yo + t_dzh;
                c_next = t_oxx + t_oyy - t_ozo;
            end
            MODE_HYP_PARAB:
            begin
                a_next   = t_xx - t_yy;
                b_next   = -t_xo + t_yo + t_dzh;
                c_next   = t_oxx - t_oyy - t_ozo;
                lin_next = 1'b1;
            end
            default:
            begin
                plane_next = 1'b1;
            end
        endcase
    end

    // common scaling keeps roots, so all three drop two bits together
    always_comb
    begin
        fit     = fits62(a_reg) && fits62(b_reg) && fits62(c_reg);
        ar_next = fit ? a_reg[RED_W-1:0] : a_reg[RED_W+1:2];
        br_next = fit ? b_reg[RED_W-1:0] : b_reg[RED_W+1:2];
        cr_next = fit ? c_reg[RED_W-1:0] : c_reg[RED_W+1:2];
        side3_next.kind = KIND_NONE;
        side3_next.num  = NUM_W'(br_next);
        side3_next.den  = NUM_W'(ar_next);
        if (plane_reg)
        begin
            side3_next.kind = KIND_SINGLE;
            side3_next.num  = -NUM_W'(oz2_reg);
            side3_next.den  = NUM_W'(dz2_reg);
        end
        else if (lin_reg && (a_reg == '0))
        begin
            side3_next.kind = KIND_SINGLE;
            side3_next.num  = NUM_W'(cr_next);
            side3_next.den  = NUM_W'(br_next) <<< 1;
        end
        else if (ar_next != '0)
        begin
            side3_next.kind = KIND_QUAD;
        end
    end

    always_comb
    begin
        p1_next = {bb_hh_reg, 64'd0} + (128'(bb_lh_reg) << 33) + 128'(bb_ll_reg);
        p2_next = {ac_hh_reg, 64'd0} + (128'(ac_lh_reg) << 32)
                + (128'(ac_hl_reg) << 32) + 128'(ac_ll_reg);
    end

    // d = b*b - a*c
    always_comb
    begin
        if (ac_neg6_reg)
        begin
            d_next = {1'b0, p1_reg} + {1'b0, p2_reg};
        end
        else
        begin
            d_next = {1'b0, p1_reg} - {1'b0, p2_reg};
        end
        side7_next = side6_reg;
        if ((side6_reg.kind == KIND_QUAD) && d_next[128])
        begin
            side7_next.kind = KIND_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxx_reg   <= dx * dx;
            pyy_reg   <= dy * dy;
            pzz_reg   <= dz * dz;
            pxo_reg   <= dx * ox;
            pyo_reg   <= dy * oy;
            pzo_reg   <= dz * oz;
            poxx_reg  <= ox * ox;
            poyy_reg  <= oy * oy;
            pozz_reg  <= oz * oz;
            dz1_reg   <= dz;
            oz1_reg   <= oz;
            mode1_reg <= cfg.shape_mode;

            a_reg     <= a_next;
            b_reg     <= b_next;
            c_reg     <= c_next;
            lin_reg   <= lin_next;
            plane_reg <= plane_next;
            dz2_reg   <= dz1_reg;
            oz2_reg   <= oz1_reg;

            ar_reg    <= ar_next;
            br_reg    <= br_next;
            cr_reg    <= cr_next;
            side3_reg <= side3_next;

            br_mag_reg  <= br_reg[63] ? 64'(-br_reg) : br_reg;
            ar_mag_reg  <= ar_reg[63] ? 64'(-ar_reg) : ar_reg;
            cr_mag_reg  <= cr_reg[63] ? 64'(-cr_reg) : cr_reg;
            ac_neg4_reg <= ar_reg[63] ^ cr_reg[63];
            side4_reg   <= side3_reg;

            bb_ll_reg   <= br_mag_reg[31:0] * br_mag_reg[31:0];
            bb_lh_reg   <= br_mag_reg[31:0] * br_mag_reg[63:32];
            bb_hh_reg   <= br_mag_reg[63:32] * br_mag_reg[63:32];
            ac_ll_reg   <= ar_mag_reg[31:0] * cr_mag_reg[31:0];
            ac_lh_reg   <= ar_mag_reg[31:0] * cr_mag_reg[63:32];
            ac_hl_reg   <= ar_mag_reg[63:32] * cr_mag_reg[31:0];
            ac_hh_reg   <= ar_mag_reg[63:32] * cr_mag_reg[63:32];
            ac_neg5_reg <= ac_neg4_reg;
            side5_reg   <= side4_reg;

            p1_reg      <= p1_next;
            p2_reg      <= p2_next;
            ac_neg6_reg <= ac_neg5_reg;
            side6_reg   <= side5_reg;

            rad_reg   <= d_next[RAD_W-1:0];
            side7_reg <= side7_next;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_rad   = rad_reg;
    assign out_side  = side7_reg;

endmodule

[src/rqi_sqrt.sv]
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module rqi_sqrt
    import rqi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RAD_W-1:0]  in_rad,
    input  side_t             in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output side_t             out_side
);

    logic [SQRT_STEPS:1]  vld_reg;
    logic [REM_W-1:0]     rem_reg  [1:SQRT_STEPS];
    logic [ROOT_W-1:0]    root_reg [1:SQRT_STEPS];
    logic [RAD_W-1:0]     rad_reg  [1:SQRT_STEPS];
    side_t                side_reg [1:SQRT_STEPS];

    logic [SQRT_STEPS:0]  st_vld;
    logic [REM_W-1:0]     st_rem  [0:SQRT_STEPS];
    logic [ROOT_W-1:0]    st_root [0:SQRT_STEPS];
    logic [RAD_W-1:0]     st_rad  [0:SQRT_STEPS];
    side_t                st_side [0:SQRT_STEPS];

    assign st_vld[0]  = in_valid;
    assign st_rem[0]  = '0;
    assign st_root[0] = '0;
    assign st_rad[0]  = in_rad;
    assign st_side[0] = in_side;

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_step
            logic [REM_W+1:0]  t_rem;
            logic [REM_W+1:0]  trial;
            logic              take;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            always_comb
            begin
                t_rem     = {st_rem[k], st_rad[k][RAD_W-1:RAD_W-2]};
                trial     = {2'b00, st_root[k], 2'b01};
                take      = t_rem >= trial;
                rem_next  = take ? REM_W'(t_rem - trial) : t_rem[REM_W-1:0];
                root_next = {st_root[k][ROOT_W-2:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[k+1] <= st_vld[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k+1]  <= rem_next;
                    root_reg[k+1] <= root_next;
                    rad_reg[k+1]  <= {st_rad[k][RAD_W-3:0], 2'b00};
                    side_reg[k+1] <= st_side[k];
                end
            end

            assign st_vld[k+1]  = vld_reg[k+1];
            assign st_rem[k+1]  = rem_reg[k+1];
            assign st_root[k+1] = root_reg[k+1];
            assign st_rad[k+1]  = rad_reg[k+1];
            assign st_side[k+1] = side_reg[k+1];
        end
    endgenerate

    assign out_valid = st_vld[SQRT_STEPS];
    assign out_root  = st_root[SQRT_STEPS];
    assign out_side  = st_side[SQRT_STEPS];

endmodule

[src/rqi_div.sv]
// two-lane pipelined divider for the positive roots, with saturation
`timescale 1ns / 1ps

module rqi_div
    import rqi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [ROOT_W-1:0] in_root,
    input  side_t             in_side,
    output logic              out_valid,
    output result_t           out_result
);

    typedef struct packed {
        logic        pos;
        logic        sat;
        logic [63:0] dm;
        logic [63:0] rem;
        logic [31:0] quo;
        logic [31:0] low;
    } lane_t;

    logic [DIV_STEPS+2:0] vld_reg;

    // numerators and signs
    logic [1:0]               pos1_reg, pos1_next;
    logic signed [NUM_W:0]    n1_reg [2];
    logic signed [NUM_W:0]    n1_next [2];
    logic signed [NUM_W-1:0]  den1_reg;

    // magnitudes
    logic [1:0]  pos2_reg;
    logic [63:0] nm2_reg [2];
    logic [63:0] dm2_reg;

    lane_t lane_reg [0:DIV_STEPS][2];
    lane_t lane0_next [2];

    always_comb
    begin
        n1_next[0] = $signed({in_side.num[NUM_W-1], in_side.num})
                   + $signed({4'b0000, in_root});
        n1_next[1] = $signed({in_side.num[NUM_W-1], in_side.num})
                   - $signed({4'b0000, in_root});
        if (in_side.kind == KIND_SINGLE)
        begin
            n1_next[0] = $signed({in_side.num[NUM_W-1], in_side.num});
        end
        for (int l = 0; l < 2; l++)
        begin
            pos1_next[l] = (n1_next[l] != '0) && (in_side.den != '0)
                         && (n1_next[l][NUM_W] == in_side.den[NUM_W-1]);
        end
        if (in_side.kind == KIND_NONE)
        begin
            pos1_next = 2'b00;
        end
        else if (in_side.kind == KIND_SINGLE)
        begin
            pos1_next[1] = 1'b0;
        end
    end

    // quotient of 2^32 or more saturates; otherwise the top bits start below dm
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            lane0_next[l].pos = pos2_reg[l];
            lane0_next[l].sat = {{SAT_SH{1'b0}}, nm2_reg[l]} >= {dm2_reg, {SAT_SH{1'b0}}};
            lane0_next[l].dm  = dm2_reg;
            lane0_next[l].rem = {{SAT_SH{1'b0}}, nm2_reg[l][63:SAT_SH]};
            lane0_next[l].quo = '0;
            lane0_next[l].low = {nm2_reg[l][SAT_SH-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS+1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos1_reg <= pos1_next;
            den1_reg <= in_side.den;
            pos2_reg <= pos1_reg;
            dm2_reg  <= den1_reg[NUM_W-1] ? 64'(-den1_reg) : den1_reg[63:0];
            for (int l = 0; l < 2; l++)
            begin
                n1_reg[l]     <= n1_next[l];
                nm2_reg[l]    <= n1_reg[l][NUM_W] ? 64'(-n1_reg[l]) : n1_reg[l][63:0];
                lane_reg[0][l] <= lane0_next[l];
            end
        end
    end

    genvar k, m;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            for (m = 0; m < 2; m++)
            begin : g_lane
                logic [64:0] t;
                logic        ge;
                lane_t       lane_next;

                always_comb
                begin
                    t             = {lane_reg[k][m].rem, lane_reg[k][m].low[31]};
                    ge            = t >= {1'b0, lane_reg[k][m].dm};
                    lane_next     = lane_reg[k][m];
                    lane_next.rem = ge ? 64'(t - {1'b0, lane_reg[k][m].dm}) : t[63:0];
                    lane_next.quo = {lane_reg[k][m].quo[30:0], ge};
                    lane_next.low = {lane_reg[k][m].low[30:0], 1'b0};
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        lane_reg[k+1][m] <= lane_next;
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            out_result.hit[l]      = lane_reg[DIV_STEPS][l].pos;
            out_result.distance[l] = lane_reg[DIV_STEPS][l].sat ? '1
                                   : lane_reg[DIV_STEPS][l].quo;
        end
    end

    assign out_valid = vld_reg[DIV_STEPS+2];

endmodule

[src/rqi_back.sv]
// back: result queue and result item emitter
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rqi_back
    import rqi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  result_t           push_data,
    output logic              full,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit,
    output logic [DIST_W-1:0] m_dist,
    output logic              m_last
);

    result_t             fifo_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]  count_reg, count_next;
    logic                phase_reg, phase_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_hit_reg, m_hit_next;
    logic [DIST_W-1:0]   m_dist_reg, m_dist_next;
    logic                m_last_reg, m_last_next;
    result_t             head;
    logic                load, have, pop;

    assign head = fifo_reg[rd_ptr_reg];
    assign load = !m_valid_reg || m_ready;
    assign have = count_reg != '0;
    assign full = count_reg == Q_CNT_W'(Q_DEPTH);

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_ready;
        m_hit_next   = m_hit_reg;
        m_dist_next  = m_dist_reg;
        m_last_next  = m_last_reg;
        phase_next   = phase_reg;
        pop          = 1'b0;
        if (load && have)
        begin
            m_valid_next = 1'b1;
            if (phase_reg)
            begin
                m_hit_next  = 1'b1;
                m_dist_next = head.distance[1];
                m_last_next = 1'b1;
                phase_next  = 1'b0;
                pop         = 1'b1;
            end
            else if (head.hit[0])
            begin
                m_hit_next  = 1'b1;
                m_dist_next = head.distance[0];
                m_last_next = !head.hit[1];
                phase_next  = head.hit[1];
                pop         = !head.hit[1];
            end
            else if (head.hit[1])
            begin
                m_hit_next  = 1'b1;
                m_dist_next = head.distance[1];
                m_last_next = 1'b1;
                pop         = 1'b1;
            end
            else
            begin
                // miss: one empty item
                m_hit_next  = 1'b0;
                m_dist_next = '0;
                m_last_next = 1'b1;
                pop         = 1'b1;
            end
        end
        count_next = count_reg + Q_CNT_W'(push) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
        m_hit_reg  <= m_hit_next;
        m_dist_reg <= m_dist_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;
    assign m_dist  = m_dist_reg;
    assign m_last  = m_last_reg;

    `RQI_ASSERT(a_count_range, count_reg <= Q_CNT_W'(Q_DEPTH))
    `RQI_ASSERT_IMP(a_pop_nonempty, pop, count_reg != '0)
    `RQI_ASSERT_IMP(a_second_root_held, phase_reg, (count_reg != '0) && head.hit[1])

endmodule

[src/ray_quadric_intersect.sv]
// top level: ray / unit quadric intersection stream
`timescale 1ns / 1ps

// channel   | handshake                     | payload
// ----------+-------------------------------+---------------------------------
// s_axis    | s_axis_tvalid / s_axis_tready | tdata: dir_x, dir_y, dir_z
// m_axis    | m_axis_tvalid / m_axis_tready | tuser: hit, tdata: distance,
//           |                               | tlast: last
// cfg       | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// one ray request per cycle unless stalled; the pipeline is 105 stages deep
// (7 for the terms and discriminant, 63 for the square root at one root bit
// per stage, 35 for the two divider lanes, setup then one quotient bit per stage)
// a ray with two hits gives two output items, all others one
// the whole pipeline stalls together only when its last stage holds a result
// and the four-entry result queue is full
// reset clears the pipeline valids, queue and output; registers return to
// sphere mode with the origin at zero; cfg_ready is always high

module ray_quadric_intersect
    import rqi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // dir_x [31:0], dir_y [63:32], dir_z [95:64]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // distance [31:0]
    output logic [0:0]  m_axis_tuser,   // hit [0]
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t              cfg_reg;
    logic              en;

    logic              fr_valid;
    logic [RAD_W-1:0]  fr_rad;
    side_t             fr_side;

    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    side_t             sq_side;

    logic              dv_valid;
    result_t           dv_result;

    logic              q_full;

    // user keeps configuration writes to idle times; the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shape_mode <= MODE_SPHERE;
            cfg_reg.origin_x   <= '0;
            cfg_reg.origin_y   <= '0;
            cfg_reg.origin_z   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SHAPE_MODE: cfg_reg.shape_mode <= cfg_data[2:0];
                CFG_ORIGIN_X:   cfg_reg.origin_x   <= cfg_data;
                CFG_ORIGIN_Y:   cfg_reg.origin_y   <= cfg_data;
                CFG_ORIGIN_Z:   cfg_reg.origin_z   <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // global advance: stall only if the last stage would overflow the queue
    assign en            = !(dv_valid && q_full);
    assign s_axis_tready = en;

    rqi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .dir_x     (s_axis_tdata[31:0]),
        .dir_y     (s_axis_tdata[63:32]),
        .dir_z     (s_axis_tdata[95:64]),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_side  (fr_side)
    );

    rqi_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_rad    (fr_rad),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    rqi_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (sq_valid),
        .in_root    (sq_root),
        .in_side    (sq_side),
        .out_valid  (dv_valid),
        .out_result (dv_result)
    );

    rqi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (dv_valid && en),
        .push_data (dv_result),
        .full      (q_full),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_hit     (m_axis_tuser[0]),
        .m_dist    (m_axis_tdata),
        .m_last    (m_axis_tlast)
    );

endmodule
